[rtl/rcfm_pkg.sv]
// ----------------------------------------------------------------------------
// rcfm_pkg: shared types and constants of the RC channel failsafe mapper
// Holds the action and register codes, field widths, scaling constants and
// the result beat type.
// ----------------------------------------------------------------------------
package rcfm_pkg;

  localparam int RAW_W   = 11;
  localparam int PULSE_W = 12;
  localparam int MS_W    = 16;
  localparam int MAP_W   = 16;
  localparam int IDX_W   = 4;
  localparam int GRP_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int RAW_PORTS = 4;

  localparam logic [RAW_W-1:0]   RAW_MIN   = 11'd172;
  localparam logic [PULSE_W-1:0] PULSE_MIN = 12'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd2000;

  // floor(d * 1000 / 1639) == (d * SCALE_RECIP) >> SCALE_SHIFT for d in 0..1639.
  localparam int SCALE_SHIFT = 22;
  localparam logic [SCALE_SHIFT-1:0] SCALE_RECIP = 22'd2559063;

  localparam logic [PULSE_W-1:0] RST_NEUTRAL  = 12'd1500;
  localparam logic [MS_W-1:0]    RST_TIMEOUT  = 16'd500;
  localparam logic [PULSE_W-1:0] RST_FS_THR   = 12'd1000;
  localparam logic [PULSE_W-1:0] RST_FS_AIL   = 12'd1500;
  localparam logic [PULSE_W-1:0] RST_FS_ELE   = 12'd1500;
  localparam logic [PULSE_W-1:0] RST_FS_RUD   = 12'd1500;
  localparam logic [MAP_W-1:0]   RST_FUNC_MAP = 16'h3102;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_GROUP = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEUTRAL  = 3'd0,
    REG_TIMEOUT  = 3'd1,
    REG_FS_THR   = 3'd2,
    REG_FS_AIL   = 3'd3,
    REG_FS_ELE   = 3'd4,
    REG_FS_RUD   = 3'd5,
    REG_FUNC_MAP = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PULSE_W-1:0] channel_pulse;
    logic               link_valid;
    logic               in_failsafe;
    logic [MS_W-1:0]    ms_since_valid;
  } out_beat_t;

endpackage

[rtl/rcfm_if.sv]
// ----------------------------------------------------------------------------
// rcfm_if: channel interfaces of the RC channel failsafe mapper
// Item, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface rcfm_item_if;
  logic                             valid;
  logic                             ready;
  rcfm_pkg::action_e                action;
  logic [rcfm_pkg::GRP_W-1:0]       channel_group;
  logic [rcfm_pkg::RAW_W-1:0]       raw_ch0;
  logic [rcfm_pkg::RAW_W-1:0]       raw_ch1;
  logic [rcfm_pkg::RAW_W-1:0]       raw_ch2;
  logic [rcfm_pkg::RAW_W-1:0]       raw_ch3;
  logic                             frame_failsafe;
  logic [rcfm_pkg::IDX_W-1:0]       read_index;

  modport source (output valid, action, channel_group, raw_ch0, raw_ch1, raw_ch2, raw_ch3,
                  frame_failsafe, read_index, input ready);
  modport sink   (input valid, action, channel_group, raw_ch0, raw_ch1, raw_ch2, raw_ch3,
                  frame_failsafe, read_index, output ready);
endinterface

interface rcfm_result_if;
  logic                             valid;
  logic                             ready;
  logic [rcfm_pkg::PULSE_W-1:0]     channel_pulse;
  logic                             link_valid;
  logic                             in_failsafe;
  logic [rcfm_pkg::MS_W-1:0]        ms_since_valid;

  modport source (output valid, channel_pulse, link_valid, in_failsafe, ms_since_valid,
                  input ready);
  modport sink   (input valid, channel_pulse, link_valid, in_failsafe, ms_since_valid,
                  output ready);
endinterface

interface rcfm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rcfm_pkg::CFG_IDX_W-1:0]   index;
  logic [rcfm_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rcfm_lane.sv]
// ----------------------------------------------------------------------------
// rcfm_lane: one channel scaling lane
// Maps a raw SBUS value 172..1811 onto 1000..2000 us, truncating and clamped.
// ----------------------------------------------------------------------------
module rcfm_lane (
  input  logic [rcfm_pkg::RAW_W-1:0]   raw_i,
  output logic [rcfm_pkg::PULSE_W-1:0] pulse_o
);

  localparam int PROD_W = rcfm_pkg::RAW_W + rcfm_pkg::SCALE_SHIFT;

  logic [rcfm_pkg::RAW_W-1:0]   delta;
  logic [PROD_W-1:0]            prod;
  logic [rcfm_pkg::RAW_W-1:0]   quot;
  logic [rcfm_pkg::PULSE_W-1:0] sum;

  // The reciprocal product is exact up to the top of the raw range; beyond
  // it the quotient only grows, so the clamp below catches it.
  assign delta = (raw_i > rcfm_pkg::RAW_MIN) ? (raw_i - rcfm_pkg::RAW_MIN) : '0;
  assign prod  = PROD_W'(delta) * PROD_W'(rcfm_pkg::SCALE_RECIP);
  assign quot  = prod[PROD_W-1:rcfm_pkg::SCALE_SHIFT];
  assign sum   = rcfm_pkg::PULSE_W'(quot) + rcfm_pkg::PULSE_MIN;

  assign pulse_o = (sum > rcfm_pkg::PULSE_MAX) ? rcfm_pkg::PULSE_MAX : sum;

endmodule

[rtl/rcfm_out_fifo.sv]
// ----------------------------------------------------------------------------
// rcfm_out_fifo: two-entry result buffer
// Registers result beats and keeps the item side running while the result
// side stalls, until both entries are held.
// ----------------------------------------------------------------------------
module rcfm_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rcfm_pkg::out_beat_t   push_data_i,
  output logic                  can_push_o,
  rcfm_result_if.source         result_o
);

  rcfm_pkg::out_beat_t ent_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                pop;
  rcfm_pkg::out_beat_t head;

  assign pop        = result_o.valid && result_o.ready;
  assign can_push_o = (cnt_q != 2'd2);
  assign head       = ent_q[rd_ptr_q];

  assign result_o.valid          = (cnt_q != 2'd0);
  assign result_o.channel_pulse  = head.channel_pulse;
  assign result_o.link_valid     = head.link_valid;
  assign result_o.in_failsafe    = head.in_failsafe;
  assign result_o.ms_since_valid = head.ms_since_valid;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/rc_channel_failsafe_mapper.sv]
// ----------------------------------------------------------------------------
// rc_channel_failsafe_mapper: SBUS channel scaling with failsafe
//
//   channel   dir  modport  beat contents
//   item_i    in   sink     action, channel_group, raw_ch0..3, frame_failsafe,
//                           read_index
//   result_o  out  source   channel_pulse, link_valid, in_failsafe,
//                           ms_since_valid
//   cfg_i     in   sink     index, data (always ready)
//
// One item is accepted per cycle while item_i.ready is high.
// Four scaling lanes (one reciprocal multiplier each) map a channel group in
// the cycle it is accepted, and a merge stage writes them into the store.
// A two-entry result buffer registers the beats and lets items flow while the
// result side stalls; item_i.ready drops only when both entries are held.
// Reset loads the register defaults and sets every stored channel to 1500.
// ----------------------------------------------------------------------------
module rc_channel_failsafe_mapper #(
  parameter int NUM_CHANNELS = 16,
  parameter int LANES        = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rcfm_item_if.sink      item_i,
  rcfm_result_if.source  result_o,
  rcfm_cfg_if.sink       cfg_i
);

  localparam int NLANES = (LANES < rcfm_pkg::RAW_PORTS) ? LANES : rcfm_pkg::RAW_PORTS;
  localparam int CH_W   = $clog2(NUM_CHANNELS);
  localparam int CHN_W  = $clog2(4 * LANES);

  // Configuration registers.
  logic [rcfm_pkg::PULSE_W-1:0] neutral_q;
  logic [rcfm_pkg::MS_W-1:0]    timeout_q;
  logic [rcfm_pkg::PULSE_W-1:0] fs_thr_q;
  logic [rcfm_pkg::PULSE_W-1:0] fs_ail_q;
  logic [rcfm_pkg::PULSE_W-1:0] fs_ele_q;
  logic [rcfm_pkg::PULSE_W-1:0] fs_rud_q;
  logic [rcfm_pkg::MAP_W-1:0]   fmap_q;

  // Link state and channel store.
  logic [rcfm_pkg::PULSE_W-1:0] store_q [NUM_CHANNELS];
  logic [rcfm_pkg::PULSE_W-1:0] store_d [NUM_CHANNELS];
  logic                         link_q, link_d;
  logic                         fs_q, fs_d;
  logic [rcfm_pkg::MS_W-1:0]    sc_q, sc_d;

  logic                         acc;
  logic                         can_push;
  logic [rcfm_pkg::RAW_W-1:0]   raw [rcfm_pkg::RAW_PORTS];
  logic [rcfm_pkg::PULSE_W-1:0] lane_pulse [NLANES];
  logic [CHN_W-1:0]             lane_ch [NLANES];
  logic [rcfm_pkg::PULSE_W-1:0] read_pulse;
  logic [rcfm_pkg::PULSE_W-1:0] pulse;
  rcfm_pkg::out_beat_t          beat;

  assign acc          = item_i.valid && item_i.ready;
  assign item_i.ready = can_push;
  assign cfg_i.ready  = 1'b1;

  assign raw[0] = item_i.raw_ch0;
  assign raw[1] = item_i.raw_ch1;
  assign raw[2] = item_i.raw_ch2;
  assign raw[3] = item_i.raw_ch3;

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    rcfm_lane u_lane (
      .raw_i   (raw[k]),
      .pulse_o (lane_pulse[k])
    );
    assign lane_ch[k] = CHN_W'(item_i.channel_group) * CHN_W'(LANES) + CHN_W'(k);
  end

  // Read path: failsafe substitution takes priority throttle, roll, pitch, yaw.
  always_comb begin
    if (fs_q) begin
      if (item_i.read_index == fmap_q[3:0]) begin
        read_pulse = fs_thr_q;
      end else if (item_i.read_index == fmap_q[7:4]) begin
        read_pulse = fs_ail_q;
      end else if (item_i.read_index == fmap_q[11:8]) begin
        read_pulse = fs_ele_q;
      end else if (item_i.read_index == fmap_q[15:12]) begin
        read_pulse = fs_rud_q;
      end else begin
        read_pulse = neutral_q;
      end
    end else if (int'(item_i.read_index) < NUM_CHANNELS) begin
      read_pulse = store_q[item_i.read_index[CH_W-1:0]];
    end else begin
      read_pulse = neutral_q;
    end
  end

  // Merge stage and link state update.
  always_comb begin
    sc_d    = sc_q;
    fs_d    = fs_q;
    link_d  = link_q;
    pulse   = '0;
    store_d = store_q;
    if (acc) begin
      case (item_i.action)
        rcfm_pkg::ACT_TICK: begin
          if (sc_q != '1) begin
            sc_d = sc_q + rcfm_pkg::MS_W'(1);
          end
          if (sc_d > timeout_q) begin
            fs_d   = 1'b1;
            link_d = 1'b0;
          end
        end
        rcfm_pkg::ACT_GROUP: begin
          if (item_i.frame_failsafe) begin
            fs_d   = 1'b1;
            link_d = 1'b0;
          end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              for (int k = 0; k < NLANES; k++) begin
                if (int'(lane_ch[k]) == i) begin
                  store_d[i] = lane_pulse[k];
                end
              end
            end
            link_d = 1'b1;
            fs_d   = 1'b0;
            sc_d   = '0;
          end
        end
        rcfm_pkg::ACT_READ: begin
          pulse = read_pulse;
        end
        default: begin
        end
      endcase
    end
  end

  assign beat.channel_pulse  = pulse;
  assign beat.link_valid     = link_d && !fs_d;
  assign beat.in_failsafe    = fs_d;
  assign beat.ms_since_valid = sc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= 1'b0;
      fs_q   <= 1'b0;
      sc_q   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_q[i] <= rcfm_pkg::RST_NEUTRAL;
      end
    end else begin
      link_q  <= link_d;
      fs_q    <= fs_d;
      sc_q    <= sc_d;
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= rcfm_pkg::RST_NEUTRAL;
      timeout_q <= rcfm_pkg::RST_TIMEOUT;
      fs_thr_q  <= rcfm_pkg::RST_FS_THR;
      fs_ail_q  <= rcfm_pkg::RST_FS_AIL;
      fs_ele_q  <= rcfm_pkg::RST_FS_ELE;
      fs_rud_q  <= rcfm_pkg::RST_FS_RUD;
      fmap_q    <= rcfm_pkg::RST_FUNC_MAP;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (rcfm_pkg::cfg_reg_e'(cfg_i.index))
        rcfm_pkg::REG_NEUTRAL:  neutral_q <= cfg_i.data[rcfm_pkg::PULSE_W-1:0];
        rcfm_pkg::REG_TIMEOUT:  timeout_q <= cfg_i.data[rcfm_pkg::MS_W-1:0];
        rcfm_pkg::REG_FS_THR:   fs_thr_q  <= cfg_i.data[rcfm_pkg::PULSE_W-1:0];
        rcfm_pkg::REG_FS_AIL:   fs_ail_q  <= cfg_i.data[rcfm_pkg::PULSE_W-1:0];
        rcfm_pkg::REG_FS_ELE:   fs_ele_q  <= cfg_i.data[rcfm_pkg::PULSE_W-1:0];
        rcfm_pkg::REG_FS_RUD:   fs_rud_q  <= cfg_i.data[rcfm_pkg::PULSE_W-1:0];
        rcfm_pkg::REG_FUNC_MAP: fmap_q    <= cfg_i.data[rcfm_pkg::MAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcfm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .push_data_i (beat),
    .can_push_o  (can_push),
    .result_o    (result_o)
  );

`ifndef SYNTHESIS
  // Failsafe always drops the link.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fs_q |-> !link_q)
    else $error("link marked valid while in failsafe");

  // A good frame group restarts the silence counter and leaves failsafe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && item_i.action == rcfm_pkg::ACT_GROUP && !item_i.frame_failsafe
    |=> sc_q == '0 && !fs_q && link_q)
    else $error("good group did not restore the link");

  // The silence counter saturates on ticks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && item_i.action == rcfm_pkg::ACT_TICK && sc_q == '1 |=> sc_q == '1)
    else $error("silence counter wrapped");

  // Only a tick or a group moves the link state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc || item_i.action == rcfm_pkg::ACT_READ || item_i.action == rcfm_pkg::ACT_NOP
    |=> $stable(fs_q) && $stable(link_q) && $stable(sc_q))
    else $error("link state changed without a tick or group");
`endif

endmodule

[sim/rc_channel_failsafe_mapper_tb.sv]
// ----------------------------------------------------------------------------
// rc_channel_failsafe_mapper_tb: self-checking regression of the failsafe mapper
// Drives channel groups, millisecond ticks and channel reads into the block.
// An in-bench predictor of the channel store, link state and silence counter
// computes every result beat, and each beat is checked field by field. The run
// steps through several register settings, extremes included, with random
// idling on both sides and long result-side hold-offs.
// ----------------------------------------------------------------------------
module rc_channel_failsafe_mapper_tb;

  localparam int NUM_CH       = 16;
  localparam int LANE_COUNT   = 4;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    rcfm_pkg::action_e                                           action;
    logic [rcfm_pkg::GRP_W-1:0]                                  channel_group;
    logic [rcfm_pkg::RAW_PORTS-1:0][rcfm_pkg::RAW_W-1:0]         raw;
    logic                                                        frame_failsafe;
    logic [rcfm_pkg::IDX_W-1:0]                                  read_index;
  } item_t;

  logic clk_i;
  logic rst_ni;

  rcfm_item_if   item_bus ();
  rcfm_result_if result_bus ();
  rcfm_cfg_if    cfg_bus ();

  rc_channel_failsafe_mapper #(
    .NUM_CHANNELS(NUM_CH),
    .LANES       (LANE_COUNT)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  // Predicted block state and register copies.
  logic [rcfm_pkg::PULSE_W-1:0] store_pulse [NUM_CH];
  logic                         link_up;
  logic                         fs_active;
  logic [rcfm_pkg::MS_W-1:0]    silence_ms;
  logic [rcfm_pkg::PULSE_W-1:0] cfg_neutral, cfg_fs_thr, cfg_fs_ail, cfg_fs_ele, cfg_fs_rud;
  logic [rcfm_pkg::MS_W-1:0]    cfg_timeout;
  logic [rcfm_pkg::MAP_W-1:0]   cfg_func_map;

  item_t               item_backlog [$];
  rcfm_pkg::out_beat_t due_beats [$];
  item_t               driven_item;
  int                  items_queued;
  int                  items_accepted;
  int                  mismatch_count;
  int                  cycle_count;
  int                  hold_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("rc_channel_failsafe_mapper regression: fail");
      $finish;
    end
  end

  // Random breaks are off on both sides for the first part of each cycle_count window.
  function automatic bit take_break();
    return ((cycle_count % 4096) >= 700) && ($urandom_range(99) < 17);
  endfunction

  // Advances the predicted state by one item and returns its result beat.
  function automatic rcfm_pkg::out_beat_t apply_item(item_t it);
    rcfm_pkg::out_beat_t          beat;
    logic [rcfm_pkg::PULSE_W-1:0] pulse;
    int unsigned                  ch;
    int unsigned                  scaled;
    pulse = '0;
    case (it.action)
      rcfm_pkg::ACT_TICK: begin
        if (silence_ms != '1) silence_ms = silence_ms + 1'b1;
        if (silence_ms > cfg_timeout) begin
          fs_active = 1'b1;
          link_up   = 1'b0;
        end
      end
      rcfm_pkg::ACT_GROUP: begin
        if (it.frame_failsafe) begin
          fs_active = 1'b1;
          link_up   = 1'b0;
        end else begin
          for (int k = 0; k < 4 && k < LANE_COUNT; k++) begin
            ch = it.channel_group * LANE_COUNT + k;
            if (it.raw[k] <= rcfm_pkg::RAW_MIN) begin
              scaled = rcfm_pkg::PULSE_MIN;
            end else begin
              scaled = (it.raw[k] - rcfm_pkg::RAW_MIN) * 1000 / 1639 + rcfm_pkg::PULSE_MIN;
            end
            if (scaled > rcfm_pkg::PULSE_MAX) scaled = rcfm_pkg::PULSE_MAX;
            if (ch < NUM_CH) store_pulse[ch] = scaled[rcfm_pkg::PULSE_W-1:0];
          end
          link_up    = 1'b1;
          fs_active  = 1'b0;
          silence_ms = '0;
        end
      end
      rcfm_pkg::ACT_READ: begin
        // In failsafe the function map decides, throttle first.
        if (fs_active) begin
          if (it.read_index == cfg_func_map[3:0]) pulse = cfg_fs_thr;
          else if (it.read_index == cfg_func_map[7:4]) pulse = cfg_fs_ail;
          else if (it.read_index == cfg_func_map[11:8]) pulse = cfg_fs_ele;
          else if (it.read_index == cfg_func_map[15:12]) pulse = cfg_fs_rud;
          else pulse = cfg_neutral;
        end else if (it.read_index < NUM_CH) begin
          pulse = store_pulse[it.read_index];
        end else begin
          pulse = cfg_neutral;
        end
      end
      default: ;
    endcase
    beat.channel_pulse  = pulse;
    beat.link_valid     = link_up && !fs_active;
    beat.in_failsafe    = fs_active;
    beat.ms_since_valid = silence_ms;
    return beat;
  endfunction

  // Item driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk_i) begin : drive_items
    item_t nxt;
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        due_beats.push_back(apply_item(driven_item));
        items_accepted++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (item_backlog.size() != 0 && !take_break()) begin
          nxt = item_backlog.pop_front();
          driven_item             = nxt;
          item_bus.action         <= nxt.action;
          item_bus.channel_group  <= nxt.channel_group;
          item_bus.raw_ch0        <= nxt.raw[0];
          item_bus.raw_ch1        <= nxt.raw[1];
          item_bus.raw_ch2        <= nxt.raw[2];
          item_bus.raw_ch3        <= nxt.raw[3];
          item_bus.frame_failsafe <= nxt.frame_failsafe;
          item_bus.read_index     <= nxt.read_index;
          item_bus.valid          <= 1'b1;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // A long hold-off now and then lets the result buffer fill up.
  always @(posedge clk_i) begin : hold_timer
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (cycle_count % 1000 == 500) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Result monitor: checks each beat against the oldest prediction.
  always @(posedge clk_i) begin : check_beats
    rcfm_pkg::out_beat_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (due_beats.size() == 0) begin
          $error("result beat with no item pending: channel_pulse %0d",
                 result_bus.channel_pulse);
          mismatch_count++;
        end else begin
          want = due_beats.pop_front();
          if (result_bus.channel_pulse !== want.channel_pulse) begin
            $error("channel_pulse: expected %0d, got %0d", want.channel_pulse,
                   result_bus.channel_pulse);
            mismatch_count++;
          end
          if (result_bus.link_valid !== want.link_valid) begin
            $error("link_valid: expected %0d, got %0d", want.link_valid,
                   result_bus.link_valid);
            mismatch_count++;
          end
          if (result_bus.in_failsafe !== want.in_failsafe) begin
            $error("in_failsafe: expected %0d, got %0d", want.in_failsafe,
                   result_bus.in_failsafe);
            mismatch_count++;
          end
          if (result_bus.ms_since_valid !== want.ms_since_valid) begin
            $error("ms_since_valid: expected %0d, got %0d", want.ms_since_valid,
                   result_bus.ms_since_valid);
            mismatch_count++;
          end
        end
      end
      result_bus.ready <= (hold_left == 0) && !take_break();
    end
  end

  function automatic item_t rand_item(rcfm_pkg::action_e act);
    item_t       it;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    it = bits[$bits(item_t)-1:0];
    it.action = act;
    return it;
  endfunction

  // Raw words lean toward the edges of the SBUS range.
  function automatic logic [rcfm_pkg::RAW_W-1:0] rand_raw();
    case ($urandom_range(11))
      0: return rcfm_pkg::RAW_W'(0);
      1: return rcfm_pkg::RAW_W'(171);
      2: return rcfm_pkg::RAW_W'(172);
      3: return rcfm_pkg::RAW_W'(173);
      4: return rcfm_pkg::RAW_W'(1810);
      5: return rcfm_pkg::RAW_W'(1811);
      6: return rcfm_pkg::RAW_W'(1812);
      7: return rcfm_pkg::RAW_W'(2047);
      default: return rcfm_pkg::RAW_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(item_t it);
    item_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic queue_read(logic [rcfm_pkg::IDX_W-1:0] idx);
    item_t it;
    it = rand_item(rcfm_pkg::ACT_READ);
    it.read_index = idx;
    queue_item(it);
  endtask

  task automatic queue_group(logic [rcfm_pkg::GRP_W-1:0] grp, logic fs,
                             logic [rcfm_pkg::RAW_W-1:0] r0, logic [rcfm_pkg::RAW_W-1:0] r1,
                             logic [rcfm_pkg::RAW_W-1:0] r2, logic [rcfm_pkg::RAW_W-1:0] r3);
    item_t it;
    it = rand_item(rcfm_pkg::ACT_GROUP);
    it.channel_group  = grp;
    it.frame_failsafe = fs;
    it.raw[0] = r0;
    it.raw[1] = r1;
    it.raw[2] = r2;
    it.raw[3] = r3;
    queue_item(it);
  endtask

  // Mostly whole frames, tick bursts and reads; the rest is lone groups and
  // no-op beats.
  task automatic queue_random(int count, int burst_max);
    int made;
    int pick;
    int reps;
    logic fs;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        fs = ($urandom_range(99) < 12);
        for (int g = 0; g < 4; g++)
          queue_group(rcfm_pkg::GRP_W'(g), fs, rand_raw(), rand_raw(), rand_raw(),
                      rand_raw());
        made += 4;
      end else if (pick < 55) begin
        reps = $urandom_range(burst_max, 1);
        repeat (reps) queue_item(rand_item(rcfm_pkg::ACT_TICK));
        made += reps;
      end else if (pick < 85) begin
        reps = $urandom_range(3, 1);
        repeat (reps) queue_read(rcfm_pkg::IDX_W'($urandom_range(15)));
        made += reps;
      end else if (pick < 93) begin
        queue_group(rcfm_pkg::GRP_W'($urandom_range(3)), 1'($urandom_range(1)), rand_raw(),
                    rand_raw(), rand_raw(), rand_raw());
        made++;
      end else begin
        queue_item(rand_item(rcfm_pkg::ACT_NOP));
        made++;
      end
    end
  endtask

  task automatic write_reg(rcfm_pkg::cfg_reg_e idx, logic [rcfm_pkg::CFG_DAT_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      rcfm_pkg::REG_NEUTRAL:  cfg_neutral  = value[rcfm_pkg::PULSE_W-1:0];
      rcfm_pkg::REG_TIMEOUT:  cfg_timeout  = value[rcfm_pkg::MS_W-1:0];
      rcfm_pkg::REG_FS_THR:   cfg_fs_thr   = value[rcfm_pkg::PULSE_W-1:0];
      rcfm_pkg::REG_FS_AIL:   cfg_fs_ail   = value[rcfm_pkg::PULSE_W-1:0];
      rcfm_pkg::REG_FS_ELE:   cfg_fs_ele   = value[rcfm_pkg::PULSE_W-1:0];
      rcfm_pkg::REG_FS_RUD:   cfg_fs_rud   = value[rcfm_pkg::PULSE_W-1:0];
      rcfm_pkg::REG_FUNC_MAP: cfg_func_map = value[rcfm_pkg::MAP_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_all_regs(logic [rcfm_pkg::PULSE_W-1:0] neutral,
                                logic [rcfm_pkg::MS_W-1:0] timeout,
                                logic [rcfm_pkg::PULSE_W-1:0] thr,
                                logic [rcfm_pkg::PULSE_W-1:0] ail,
                                logic [rcfm_pkg::PULSE_W-1:0] ele,
                                logic [rcfm_pkg::PULSE_W-1:0] rud,
                                logic [rcfm_pkg::MAP_W-1:0] func_map);
    write_reg(rcfm_pkg::REG_NEUTRAL, rcfm_pkg::CFG_DAT_W'(neutral));
    write_reg(rcfm_pkg::REG_TIMEOUT, timeout);
    write_reg(rcfm_pkg::REG_FS_THR, rcfm_pkg::CFG_DAT_W'(thr));
    write_reg(rcfm_pkg::REG_FS_AIL, rcfm_pkg::CFG_DAT_W'(ail));
    write_reg(rcfm_pkg::REG_FS_ELE, rcfm_pkg::CFG_DAT_W'(ele));
    write_reg(rcfm_pkg::REG_FS_RUD, rcfm_pkg::CFG_DAT_W'(rud));
    write_reg(rcfm_pkg::REG_FUNC_MAP, func_map);
  endtask

  // Every queued item accepted and every predicted beat checked, then settle.
  task automatic wait_all_results();
    while (items_accepted != items_queued || due_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cycle_count    = 0;
    hold_left      = 0;
    items_queued   = 0;
    items_accepted = 0;
    mismatch_count = 0;
    item_bus.valid          = 1'b0;
    item_bus.action         = rcfm_pkg::ACT_NOP;
    item_bus.channel_group  = '0;
    item_bus.raw_ch0        = '0;
    item_bus.raw_ch1        = '0;
    item_bus.raw_ch2        = '0;
    item_bus.raw_ch3        = '0;
    item_bus.frame_failsafe = 1'b0;
    item_bus.read_index     = '0;
    result_bus.ready        = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = rcfm_pkg::REG_NEUTRAL;
    cfg_bus.data            = '0;

    for (int i = 0; i < NUM_CH; i++) store_pulse[i] = rcfm_pkg::RST_NEUTRAL;
    link_up      = 1'b0;
    fs_active    = 1'b0;
    silence_ms   = '0;
    cfg_neutral  = rcfm_pkg::RST_NEUTRAL;
    cfg_timeout  = rcfm_pkg::RST_TIMEOUT;
    cfg_fs_thr   = rcfm_pkg::RST_FS_THR;
    cfg_fs_ail   = rcfm_pkg::RST_FS_AIL;
    cfg_fs_ele   = rcfm_pkg::RST_FS_ELE;
    cfg_fs_rud   = rcfm_pkg::RST_FS_RUD;
    cfg_func_map = rcfm_pkg::RST_FUNC_MAP;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset settings: scaling edges, every action, a
    // failsafe frame with reads of each mapped function and a recovery.
    queue_read(4'd0);
    queue_item(rand_item(rcfm_pkg::ACT_TICK));
    queue_group(2'd0, 1'b0, 11'd0, 11'd172, 11'd173, 11'd2047);
    queue_group(2'd1, 1'b0, 11'd1811, 11'd1810, 11'd1812, 11'd991);
    queue_group(2'd2, 1'b0, 11'd1000, 11'd500, 11'd1500, 11'd2000);
    queue_group(2'd3, 1'b0, 11'd171, 11'd1024, 11'd1811, 11'd0);
    queue_read(4'd0);
    queue_read(4'd3);
    queue_read(4'd5);
    queue_read(4'd15);
    queue_item(rand_item(rcfm_pkg::ACT_NOP));
    queue_item(rand_item(rcfm_pkg::ACT_TICK));
    queue_item(rand_item(rcfm_pkg::ACT_TICK));
    queue_group(2'd2, 1'b1, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
    queue_read(4'd2);
    queue_read(4'd0);
    queue_read(4'd1);
    queue_read(4'd3);
    queue_read(4'd9);
    queue_item(rand_item(rcfm_pkg::ACT_TICK));
    queue_group(2'd2, 1'b0, 11'd1200, 11'd300, 11'd1700, 11'd900);
    queue_read(4'd2);
    queue_read(4'd9);
    queue_item(rand_item(rcfm_pkg::ACT_NOP));
    wait_all_results();

    // Low extremes; every function mapped to channel 0, so throttle wins.
    write_all_regs(12'd0, 16'd1, 12'd4095, 12'd0, 12'd4095, 12'd0, 16'h0000);
    queue_random(250, 4);
    wait_all_results();

    write_all_regs(12'd4095, 16'd3, 12'd0, 12'd4095, 12'd0, 12'd4095, 16'hFFFF);
    queue_random(250, 6);
    wait_all_results();

    write_all_regs(rcfm_pkg::PULSE_W'($urandom_range(4095)),
                   rcfm_pkg::MS_W'($urandom_range(40, 1)),
                   rcfm_pkg::PULSE_W'($urandom_range(4095)),
                   rcfm_pkg::PULSE_W'($urandom_range(4095)),
                   rcfm_pkg::PULSE_W'($urandom_range(4095)),
                   rcfm_pkg::PULSE_W'($urandom_range(4095)),
                   rcfm_pkg::MAP_W'($urandom_range(65535)));
    queue_random(400, 45);
    wait_all_results();

    // Largest timeout: a long silence never enters failsafe.
    write_reg(rcfm_pkg::REG_TIMEOUT, 16'hFFFF);
    queue_group(2'd0, 1'b0, rand_raw(), rand_raw(), rand_raw(), rand_raw());
    repeat (120) queue_item(rand_item(rcfm_pkg::ACT_TICK));
    queue_read(rcfm_pkg::IDX_W'($urandom_range(15)));
    queue_random(150, 40);
    wait_all_results();

    write_all_regs(rcfm_pkg::RST_NEUTRAL, rcfm_pkg::RST_TIMEOUT, rcfm_pkg::RST_FS_THR,
                   rcfm_pkg::RST_FS_AIL, rcfm_pkg::RST_FS_ELE, rcfm_pkg::RST_FS_RUD,
                   rcfm_pkg::RST_FUNC_MAP);
    queue_random(150, 520);
    wait_all_results();

    if (mismatch_count == 0) begin
      $display("rc_channel_failsafe_mapper regression: pass");
    end else begin
      $display("rc_channel_failsafe_mapper regression: fail");
    end
    $finish;
  end

endmodule
